// ===== sv/wfs_pkg.sv =====
`default_nettype none

package wfs_pkg;

	// Fixed field widths.
	localparam int OPC_W       = 2;
	localparam int BYTE_W      = 8;
	localparam int COLOR_W     = 24;
	localparam int LED_CNT_W   = 7;
	localparam int TICK_W      = 12;
	localparam int BIT_W       = 5;
	// Wide enough for first_led + fill_count and for any LED count up to 256.
	localparam int SPAN_W      = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 8;

	// Default size of the color store.
	localparam int MAX_LEDS_DEF = 64;

	// Command queue between the front and the back (power of two).
	localparam int QUEUE_DEPTH = 2;

	// Position of the last bit of a color, counted from the first one sent.
	localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

	// Register reset values.
	localparam logic [LED_CNT_W-1:0] LED_COUNT_RST   = 7'd64;
	localparam logic [TICK_W-1:0]    SHORT_TICKS_RST = 12'd12;
	localparam logic [TICK_W-1:0]    LONG_TICKS_RST  = 12'd26;

	// Opcodes on the input tuser.
	localparam logic [OPC_W-1:0] OPC_FILL = 2'd0;
	localparam logic [OPC_W-1:0] OPC_SHOW = 2'd1;
	localparam logic [OPC_W-1:0] OPC_TICK = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd2;

	// Command kinds handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_FILL = 2'd0,
		CMD_SHOW = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [BYTE_W-1:0]   first_led;
		logic [BYTE_W-1:0]   fill_count;
		logic [COLOR_W-1:0]  color;
	} cmd_t;

	typedef struct packed {
		logic [LED_CNT_W-1:0] led_count;
		logic [TICK_W-1:0]    short_ticks;
		logic [TICK_W-1:0]    long_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/wfs_front.sv =====
`default_nettype none

module wfs_front
	import wfs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic [OPC_W-1:0]     s_tuser,
	output logic                      cmd_valid,
	output cmd_t                      cmd,
	input  wire logic                 cmd_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             in_cmd;
	logic             push;
	logic             pop;

	// Classify the incoming beat by its opcode and unpack the fill color.
	always_comb begin
		case (s_tuser)
			OPC_FILL: in_cmd.kind = CMD_FILL;
			OPC_SHOW: in_cmd.kind = CMD_SHOW;
			OPC_TICK: in_cmd.kind = CMD_TICK;
			default:  in_cmd.kind = CMD_NOP;
		endcase
		in_cmd.first_led  = s_tdata[7:0];
		in_cmd.fill_count = s_tdata[15:8];
		in_cmd.color      = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
	end

	assign s_tready  = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/wfs_back.sv =====
`default_nettype none

module wfs_back
	import wfs_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic      out_level,
	output logic      out_busy,
	output logic      out_done
);

	localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_FILL = 2'b10
	} state_t;

	// Color store with one valid bit per entry; an unwritten entry reads as black.
	logic [COLOR_W-1:0] mem_q [MAX_LEDS];
	logic [MAX_LEDS-1:0] vld_q;

	state_t             state_q, state_d;
	logic [SPAN_W-1:0]  fill_addr_q, fill_addr_d;
	logic [SPAN_W-1:0]  fill_end_q, fill_end_d;
	logic [COLOR_W-1:0] fill_color_q, fill_color_d;

	logic               sending_q, sending_d;
	logic               high_q, high_d;
	logic [IDX_W-1:0]   led_q, led_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [TICK_W-1:0]  timer_q, timer_d;
	logic [COLOR_W-1:0] pix_q;

	logic               out_valid_q;
	logic               out_level_q, out_busy_q, out_done_q;

	logic [SPAN_W-1:0]  n_act;
	logic [SPAN_W-1:0]  first_ext;
	logic [SPAN_W-1:0]  fill_sum;
	logic [SPAN_W-1:0]  fill_end;
	logic [SPAN_W-1:0]  led_next;
	logic               can_emit;
	logic               take;
	logic               emit;
	logic               emit_level, emit_busy, emit_done;
	logic               cur_bit;
	logic [TICK_W-1:0]  phase_len;
	logic [TICK_W-1:0]  timer_inc;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic               ld_en;
	logic [IDX_W-1:0]   ld_addr;

	// Active LED count, saturated at the store size.
	always_comb begin
		if (SPAN_W'(cfg.led_count) > SPAN_W'(MAX_LEDS)) begin
			n_act = SPAN_W'(MAX_LEDS);
		end else begin
			n_act = SPAN_W'(cfg.led_count);
		end
	end

	// End of a fill range, clipped at the last LED; a zero fill count runs to the end.
	assign first_ext = SPAN_W'(cmd.first_led);
	assign fill_sum  = first_ext + SPAN_W'(cmd.fill_count);
	always_comb begin
		if (cmd.fill_count == '0 || fill_sum > n_act) begin
			fill_end = n_act;
		end else begin
			fill_end = fill_sum;
		end
	end

	// Bit timing of the bit now on the line.
	assign cur_bit   = pix_q[LAST_BIT - bit_q];
	assign phase_len = (high_q == cur_bit) ? cfg.long_ticks : cfg.short_ticks;
	assign timer_inc = timer_q + 1'b1;
	assign led_next  = SPAN_W'(led_q) + 1'b1;

	assign can_emit = !out_valid_q || m_tready;
	assign take     = (state_q == ST_RUN) && cmd_valid && can_emit;
	assign cmd_pop  = take;

	// Command execution and serializer stepping.
	always_comb begin
		state_d      = state_q;
		fill_addr_d  = fill_addr_q;
		fill_end_d   = fill_end_q;
		fill_color_d = fill_color_q;
		sending_d    = sending_q;
		high_d       = high_q;
		led_d        = led_q;
		bit_d        = bit_q;
		timer_d      = timer_q;
		emit         = 1'b0;
		emit_level   = sending_q && high_q;
		emit_done    = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = fill_addr_q[IDX_W-1:0];
		ld_en        = 1'b0;
		ld_addr      = '0;

		case (state_q)
			ST_RUN: begin
				if (take) begin
					emit = 1'b1;
					case (cmd.kind)
						CMD_FILL: begin
							if (!sending_q && first_ext < n_act) begin
								fill_addr_d  = first_ext;
								fill_end_d   = fill_end;
								fill_color_d = cmd.color;
								state_d      = ST_FILL;
							end
						end
						CMD_SHOW: begin
							if (!sending_q && n_act != '0) begin
								sending_d  = 1'b1;
								high_d     = 1'b1;
								led_d      = '0;
								bit_d      = '0;
								timer_d    = '0;
								ld_en      = 1'b1;
								ld_addr    = '0;
								emit_level = 1'b1;
							end
						end
						CMD_TICK: begin
							if (sending_q) begin
								if (timer_inc < phase_len) begin
									timer_d = timer_inc;
								end else begin
									timer_d = '0;
									if (high_q) begin
										high_d = 1'b0;
										if (bit_q >= LAST_BIT && led_next >= n_act) begin
											sending_d = 1'b0;
											high_d    = 1'b1;
											led_d     = '0;
											bit_d     = '0;
											emit_done = 1'b1;
										end
									end else begin
										high_d = 1'b1;
										if (bit_q < LAST_BIT) begin
											bit_d = bit_q + 1'b1;
										end else begin
											bit_d   = '0;
											led_d   = led_next[IDX_W-1:0];
											ld_en   = 1'b1;
											ld_addr = led_next[IDX_W-1:0];
										end
									end
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FILL: begin
				// One store entry per cycle until the range end.
				wr_en       = 1'b1;
				fill_addr_d = fill_addr_q + 1'b1;
				if (fill_addr_q + 1'b1 == fill_end_q) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	assign emit_busy = sending_d;

	// Store write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= fill_color_q;
		end
	end

	// Store read port: the color of the LED about to be sent.
	always_ff @(posedge clk) begin
		if (ld_en) begin
			pix_q <= vld_q[ld_addr] ? mem_q[ld_addr] : '0;
		end
	end

	always_ff @(posedge clk) begin
		fill_addr_q  <= fill_addr_d;
		fill_end_q   <= fill_end_d;
		fill_color_q <= fill_color_d;
		if (emit) begin
			out_level_q <= emit_level;
			out_busy_q  <= emit_busy;
			out_done_q  <= emit_done;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			vld_q       <= '0;
			sending_q   <= 1'b0;
			high_q      <= 1'b1;
			led_q       <= '0;
			bit_q       <= '0;
			timer_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			sending_q <= sending_d;
			high_q    <= high_d;
			led_q     <= led_d;
			bit_q     <= bit_d;
			timer_q   <= timer_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid  = out_valid_q;
	assign out_level = out_level_q;
	assign out_busy  = out_busy_q;
	assign out_done  = out_done_q;

endmodule

`default_nettype wire

// ===== sv/ws2812_frame_store_serializer_core.sv =====
// LED chain frame store and serializer.
// Input beats carry a command in s_tuser: fill a range of the color store,
// start showing a frame, or advance the line by one clock tick. Every input
// beat produces exactly one output beat, in order, with the line level, the
// busy flag in m_tdata and the end-of-frame pulse on m_tlast.
// An accepted input beat passes through the command queue and then the
// output register on its way to the output beat.
// Ticks, shows and ignored fills run at one beat per cycle while m_tready
// stays high. A fill that writes k LEDs holds the back end until its last
// entry is written, since the color store has one write port and takes one
// entry per cycle; the queue keeps accepting until it is full.
// Reset clears the store (all LEDs black), stops any frame and loads the
// default count and pulse lengths. Configuration writes on cfg_we take effect
// at once; the user must make them while no command is in flight (unchecked).
// When the receiver holds m_tready low, the output beat stays in place, the
// back end stops after it, and s_tready drops once the queue is full.
`default_nettype none

module ws2812_frame_store_serializer_core
	import wfs_pkg::*;
#(
	parameter int MAX_LEDS = MAX_LEDS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// first_led[7:0], fill_count[15:8], red[23:16], green[31:24], blue[39:32]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  wire logic [OPC_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// line_level[0], busy_res[1], zero padding[7:2]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// frame_done
	output logic                       m_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic out_level;
	logic out_busy;
	logic out_done;

	// Configuration registers; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count   <= LED_COUNT_RST;
			cfg_q.short_ticks <= SHORT_TICKS_RST;
			cfg_q.long_ticks  <= LONG_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LED_COUNT:   cfg_q.led_count   <= cfg_wdata[LED_CNT_W-1:0];
				CFG_SHORT_TICKS: cfg_q.short_ticks <= cfg_wdata[TICK_W-1:0];
				CFG_LONG_TICKS:  cfg_q.long_ticks  <= cfg_wdata[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	wfs_back #(
		.MAX_LEDS (MAX_LEDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_level (out_level),
		.out_busy  (out_busy),
		.out_done  (out_done)
	);

	assign m_tdata = {{(OUT_DATA_W - 2){1'b0}}, out_busy, out_level};
	assign m_tlast = out_done;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
	import wfs_pkg::*;

	localparam int NUM_LEDS = MAX_LEDS_DEF;
	localparam int GAP_MAX = 12;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PRINT_CAP = 40;
	// Opcode 3 has no meaning and must leave everything alone.
	localparam logic [OPC_W-1:0] OPC_NOP = 2'd3;
	// Register index past the end of the list.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [OPC_W-1:0]  opcode;
		logic [BYTE_W-1:0] first_led;
		logic [BYTE_W-1:0] fill_count;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} strip_cmd_t;

	typedef struct packed {
		logic level;
		logic busy;
		logic done;
	} line_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid = 1'b0;
	wire                   s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OPC_W-1:0]      s_tuser = '0;
	wire                   m_tvalid;
	logic                  m_tready = 1'b0;
	wire  [OUT_DATA_W-1:0] m_tdata;
	wire                   m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ws2812_frame_store_serializer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting to be driven and line beats waiting to be seen.
	strip_cmd_t pend_q[$];
	line_beat_t line_q[$];

	int   n_pushed = 0;
	int   n_checked = 0;
	int   miss_count = 0;
	int   tx_wait = 0;
	int   rx_wait = 0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	logic quiet_in = 1'b0;
	logic quiet_out = 1'b0;

	// Register copies, written only together with the block's registers.
	logic [LED_CNT_W-1:0] reg_leds = LED_COUNT_RST;
	logic [TICK_W-1:0]    reg_short = SHORT_TICKS_RST;
	logic [TICK_W-1:0]    reg_long = LONG_TICKS_RST;

	// Shadow of the color store and the serializer, owned by the monitor.
	logic [COLOR_W-1:0] strip_rgb [NUM_LEDS];
	logic [5:0]         tx_led;
	logic [BIT_W-1:0]   tx_bit;
	logic               tx_high;
	logic [TICK_W-1:0]  tx_timer;
	logic               tx_on;

	// Apply one command to the shadow strip and return the line beat it yields.
	function automatic line_beat_t step_strip(input strip_cmd_t c);
		line_beat_t r;
		int live;
		int stop;
		logic pix_bit;
		logic [TICK_W-1:0] span;
		live = (int'(reg_leds) > NUM_LEDS) ? NUM_LEDS : int'(reg_leds);
		r.level = tx_on && tx_high;
		r.done = 1'b0;
		case (c.opcode)
			OPC_FILL: begin
				if (!tx_on && int'(c.first_led) < live) begin
					if (c.fill_count == '0)
						stop = live;
					else
						stop = int'(c.first_led) + int'(c.fill_count);
					if (stop > live)
						stop = live;
					for (int i = int'(c.first_led); i < stop; i++)
						strip_rgb[i] = {c.red, c.green, c.blue};
				end
			end
			OPC_SHOW: begin
				if (!tx_on && live > 0) begin
					tx_on = 1'b1;
					tx_led = '0;
					tx_bit = '0;
					tx_high = 1'b1;
					tx_timer = '0;
				end
				r.level = tx_on && tx_high;
			end
			OPC_TICK: begin
				if (tx_on) begin
					pix_bit = strip_rgb[tx_led][LAST_BIT - tx_bit];
					if (tx_high)
						span = pix_bit ? reg_long : reg_short;
					else
						span = pix_bit ? reg_short : reg_long;
					tx_timer = tx_timer + 1'b1;
					if (tx_timer >= span) begin
						tx_timer = '0;
						if (tx_high) begin
							tx_high = 1'b0;
							// The frame stops right after the high phase of the last bit.
							if (tx_bit >= LAST_BIT && int'(tx_led) + 1 >= live) begin
								tx_on = 1'b0;
								tx_high = 1'b1;
								tx_led = '0;
								tx_bit = '0;
								r.done = 1'b1;
							end
						end else begin
							tx_high = 1'b1;
							if (tx_bit < LAST_BIT) begin
								tx_bit = tx_bit + 1'b1;
							end else begin
								tx_bit = '0;
								tx_led = tx_led + 1'b1;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.busy = tx_on;
		return r;
	endfunction

	task automatic flag_miss(input string what, input int got_v, input int want_v);
		if (miss_count < PRINT_CAP)
			$display("beat %0d: %s got %0d want %0d", n_checked, what, got_v, want_v);
		miss_count++;
	endtask

	// Monitor: check each output beat, then predict each accepted input beat.
	always @(posedge clk) begin : mon
		strip_cmd_t got;
		line_beat_t want;
		in_taken <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++)
				strip_rgb[i] = '0;
			tx_led = '0;
			tx_bit = '0;
			tx_high = 1'b1;
			tx_timer = '0;
			tx_on = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (line_q.size() == 0) begin
					flag_miss("unexpected output beat", int'(m_tdata), 0);
				end else begin
					want = line_q.pop_front();
					if (m_tdata[0] !== want.level)
						flag_miss("line_level", int'(m_tdata[0]), int'(want.level));
					if (m_tdata[1] !== want.busy)
						flag_miss("busy", int'(m_tdata[1]), int'(want.busy));
					if (m_tdata[OUT_DATA_W-1:2] !== '0)
						flag_miss("tdata padding", int'(m_tdata[OUT_DATA_W-1:2]), 0);
					if (m_tlast !== want.done)
						flag_miss("frame_done", int'(m_tlast), int'(want.done));
					n_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				got.opcode = s_tuser;
				got.first_led = s_tdata[7:0];
				got.fill_count = s_tdata[15:8];
				got.red = s_tdata[23:16];
				got.green = s_tdata[31:24];
				got.blue = s_tdata[39:32];
				line_q.push_back(step_strip(got));
			end
		end
	end

	// Driver: present the next command after a random gap, hold it until taken.
	always @(negedge clk) begin : drv
		strip_cmd_t c;
		if (!s_tvalid || in_taken) begin
			if (tx_wait > 0) begin
				s_tvalid <= 1'b0;
				tx_wait--;
			end else if (pend_q.size() > 0) begin
				c = pend_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= c.opcode;
				s_tdata <= {c.blue, c.green, c.red, c.fill_count, c.first_led};
				tx_wait = quiet_in ? 0 : $urandom_range(0, GAP_MAX);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: after each output beat, stall for a random number of cycles.
	always @(negedge clk) begin
		if (out_taken || !m_tready) begin
			if (out_taken)
				rx_wait = quiet_out ? 0 : $urandom_range(0, GAP_MAX);
			if (rx_wait == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_wait--;
			end
		end
	end

	function automatic strip_cmd_t any_cmd();
		strip_cmd_t c;
		c.opcode = OPC_W'($urandom_range(0, 3));
		c.first_led = BYTE_W'($urandom);
		c.fill_count = BYTE_W'($urandom);
		c.red = BYTE_W'($urandom);
		c.green = BYTE_W'($urandom);
		c.blue = BYTE_W'($urandom);
		return c;
	endfunction

	function automatic strip_cmd_t make_cmd(input logic [OPC_W-1:0] op,
			input logic [BYTE_W-1:0] first, cnt, r, g, b);
		strip_cmd_t c;
		c.opcode = op;
		c.first_led = first;
		c.fill_count = cnt;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	task automatic push_cmd(input strip_cmd_t c);
		pend_q.push_back(c);
		n_pushed++;
	endtask

	// Ticks carry random payload bits, which the block must ignore.
	task automatic push_ticks(input int n);
		strip_cmd_t c;
		repeat (n) begin
			c = any_cmd();
			c.opcode = OPC_TICK;
			push_cmd(c);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			CFG_LED_COUNT:   reg_leds = val[LED_CNT_W-1:0];
			CFG_SHORT_TICKS: reg_short = val;
			CFG_LONG_TICKS:  reg_long = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Wait until every command has produced its beat, then let the back end go quiet.
	task automatic settle();
		@(negedge clk);
		while (n_checked != n_pushed)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Pick a new register setting and new idling habits for a random phase.
	task automatic random_setup();
		int pick;
		int n;
		logic [CFG_DATA_W-1:0] v;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			n = $urandom_range(1, 2);
		else if (pick < 7)
			n = $urandom_range(3, 8);
		else if (pick == 7)
			n = 0;
		else if (pick == 8)
			n = NUM_LEDS;
		else
			n = $urandom_range(NUM_LEDS + 1, 127);
		v = CFG_DATA_W'($urandom);
		v[LED_CNT_W-1:0] = LED_CNT_W'(n);
		write_reg(CFG_LED_COUNT, v);
		if ($urandom_range(0, 9) == 0)
			v = ($urandom_range(0, 1) == 0) ? {CFG_DATA_W{1'b1}} : CFG_DATA_W'($urandom);
		else
			v = CFG_DATA_W'($urandom_range(0, 3));
		write_reg(CFG_SHORT_TICKS, v);
		if ($urandom_range(0, 9) == 0)
			v = ($urandom_range(0, 1) == 0) ? {CFG_DATA_W{1'b1}} : CFG_DATA_W'($urandom);
		else
			v = CFG_DATA_W'($urandom_range(0, 3));
		write_reg(CFG_LONG_TICKS, v);
		quiet_in = ($urandom_range(0, 3) == 0);
		quiet_out = ($urandom_range(0, 3) == 0);
	endtask

	// Mostly fill-show-tick frames with random content, the rest random noise.
	task automatic random_phase(input int target);
		int made;
		int live;
		strip_cmd_t c;
		made = 0;
		live = (int'(reg_leds) > NUM_LEDS) ? NUM_LEDS : int'(reg_leds);
		@(posedge clk);
		while (made < target) begin
			if ($urandom_range(0, 3) != 0) begin
				repeat ($urandom_range(0, 3)) begin
					c = any_cmd();
					c.opcode = OPC_FILL;
					c.first_led = BYTE_W'($urandom_range(0, (live > 0) ? live - 1 : 0));
					c.fill_count = ($urandom_range(0, 3) == 0) ? '0 :
						BYTE_W'($urandom_range(1, 4));
					push_cmd(c);
					made++;
				end
				c = any_cmd();
				c.opcode = OPC_SHOW;
				push_cmd(c);
				made++;
				repeat ($urandom_range(10, 160)) begin
					c = any_cmd();
					if ($urandom_range(0, 19) != 0)
						c.opcode = OPC_TICK;
					push_cmd(c);
					made++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					push_cmd(any_cmd());
					made++;
				end
			end
		end
	endtask

	initial begin
		int total;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default setting: idle status, fill ranges at the edges, then a frame start.
		@(posedge clk);
		push_cmd(make_cmd(OPC_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		push_cmd(make_cmd(OPC_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		push_cmd(make_cmd(OPC_FILL, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF));
		push_cmd(make_cmd(OPC_FILL, 8'd63, 8'd255, 8'h5A, 8'hA5, 8'h3C));
		push_cmd(make_cmd(OPC_FILL, 8'd64, 8'd1, 8'h11, 8'h22, 8'h33));
		push_cmd(make_cmd(OPC_FILL, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00));
		push_cmd(make_cmd(OPC_FILL, 8'd0, 8'd1, 8'h80, 8'h01, 8'h7F));
		push_cmd(make_cmd(OPC_FILL, 8'd2, 8'd3, 8'h00, 8'h00, 8'h00));
		push_cmd(make_cmd(OPC_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// A second show and a fill while the frame runs are both dropped.
		push_cmd(make_cmd(OPC_SHOW, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		push_cmd(make_cmd(OPC_FILL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
		push_cmd(make_cmd(OPC_NOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		push_ticks(40);
		settle();

		// Zero-length phases, then a zero LED count ends the running frame.
		write_reg(CFG_SHORT_TICKS, '0);
		write_reg(CFG_LONG_TICKS, '0);
		write_reg(CFG_LED_COUNT, '0);
		@(posedge clk);
		push_cmd(make_cmd(OPC_FILL, 8'd0, 8'd0, 8'h12, 8'h34, 8'h56));
		push_cmd(make_cmd(OPC_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		push_ticks(60);
		push_cmd(make_cmd(OPC_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		push_cmd(make_cmd(OPC_FILL, 8'd0, 8'd0, 8'hFF, 8'h00, 8'hFF));
		push_ticks(2);
		settle();

		// A short two-LED frame that runs to its end.
		write_reg(CFG_LED_COUNT, 12'd2);
		write_reg(CFG_SHORT_TICKS, 12'd1);
		write_reg(CFG_LONG_TICKS, 12'd2);
		@(posedge clk);
		push_cmd(make_cmd(OPC_FILL, 8'd1, 8'd0, 8'hC3, 8'h3C, 8'h96));
		push_cmd(make_cmd(OPC_FILL, 8'd2, 8'd1, 8'hFF, 8'hFF, 8'hFF));
		push_cmd(make_cmd(OPC_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		push_ticks(260);
		settle();

		// The spare index is dropped; a count above the store saturates; longest phases.
		write_reg(CFG_SPARE, {CFG_DATA_W{1'b1}});
		write_reg(CFG_LED_COUNT, 12'hF7F);
		write_reg(CFG_SHORT_TICKS, {CFG_DATA_W{1'b1}});
		write_reg(CFG_LONG_TICKS, {CFG_DATA_W{1'b1}});
		@(posedge clk);
		push_cmd(make_cmd(OPC_FILL, 8'd64, 8'd0, 8'hFF, 8'hFF, 8'hFF));
		push_cmd(make_cmd(OPC_FILL, 8'd63, 8'd0, 8'hAA, 8'h55, 8'h01));
		push_cmd(make_cmd(OPC_SHOW, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		push_ticks(30);
		settle();

		// Random phases, each with its own setting; the sender waits out every phase.
		total = 0;
		while (total < RANDOM_ITEMS) begin
			random_setup();
			random_phase($urandom_range(60, 140));
			total = n_pushed;
			settle();
		end

		if (miss_count == 0 && line_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
